### src/urxrb_pkg.sv
// Shared types and constants for the serial receive ring buffer.
// Holds the transaction kind codes, the error bit layout and the register reset value.
// Has no dependencies.
package urxrb_pkg;

   localparam logic KIND_RX   = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam int ERR_FRAME_BIT    = 0;
   localparam int ERR_OVERRUN_BIT  = 1;
   localparam int ERR_OVERFLOW_BIT = 2;
   localparam int ERR_W            = 3;

   localparam logic [7:0] STOP_DISTANCE_RESET = 8'd128;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
      logic       frame_error;
      logic       overrun_error;
      logic       peer_stopped;
   } req_type;

endpackage

### src/uart_rx_ring_buffer_flow_control.sv
// Serial receive ring buffer with watermark flow control, top level.
// Depends on urxrb_pkg for kind codes, error bit layout and the request type.
//
// The req_ channel carries one transaction per received byte (req_kind is
// KIND_RX) or per read from the consumer (req_kind is KIND_READ). Each request
// produces exactly one response on the rsp_ channel with the popped byte, the
// stored last error, the fill count and the stop or resume pulse for the peer.
// The csr_ port writes the stop distance; the user must write it only while no
// transaction is in flight, as the block itself does not enforce this.
// A request is registered on acceptance. When it advances, the ring pointers,
// last error and ring memory are updated and the response register is loaded
// at that same edge, after which rsp_valid is high until the response is taken.
// One transaction per cycle is sustained while the receiver keeps rsp_ready
// high, set by the single pointer update and the single ring memory access
// made by each transaction.
// When the receiver holds rsp_ready low, the response register holds and the
// request register fills; req_ready then falls until the response is taken.
// Reset empties the ring, clears the last error, restores the stop distance
// to 128 and drops both valid flags; ring contents are left as they were.
module uart_rx_ring_buffer_flow_control
   import urxrb_pkg::*;
#(
   parameter int RING_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_rx_byte,
   input  logic       req_frame_error_in,
   input  logic       req_overrun_error_in,
   input  logic       req_peer_stopped,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_read_valid,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_last_frame_error,
   output logic       rsp_last_overrun_error,
   output logic       rsp_last_buffer_overflow,
   output logic [7:0] rsp_fill_count,
   output logic       rsp_stop_request,
   output logic       rsp_resume_request,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   localparam int PTR_W  = $clog2(RING_DEPTH);
   localparam int FILL_W = (PTR_W > 8) ? PTR_W : 8;
   localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(RING_DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_WIDE = (PTR_W + 1)'(RING_DEPTH);

   logic [7:0]       ring_mem [RING_DEPTH];
   logic [PTR_W-1:0] dist_table [256];

   req_type          s1_req_ff;
   logic             s1_valid_ff;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [ERR_W-1:0] last_error_ff, last_error_in;
   logic [7:0]       stop_distance_ff;

   logic             rsp_valid_ff;
   logic             rsp_read_valid_ff, read_valid_in;
   logic [7:0]       rsp_read_byte_ff;
   logic [ERR_W-1:0] rsp_error_ff;
   logic [7:0]       rsp_fill_count_ff;
   logic             rsp_stop_ff, stop_in;
   logic             rsp_resume_ff, resume_in;

   logic             advance;
   logic             write_en;
   logic [PTR_W-1:0] head_next, tail_next, tail_after;
   logic [PTR_W:0]   stop_sum, stop_wrap;
   logic [PTR_W-1:0] fill;
   logic [FILL_W-1:0] fill_wide;

   for (genvar g = 0; g < 256; g++) begin : g_dist
      assign dist_table[g] = PTR_W'(g % RING_DEPTH);
   end

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_comb begin
      head_next     = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
      tail_next     = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
      tail_after    = (tail_next == LAST_SLOT) ? '0 : tail_next + 1'b1;
      stop_sum      = {1'b0, head_next} + {1'b0, dist_table[stop_distance_ff]};
      stop_wrap     = (stop_sum >= DEPTH_WIDE) ? stop_sum - DEPTH_WIDE : stop_sum;
      head_in       = head_ff;
      tail_in       = tail_ff;
      last_error_in = last_error_ff;
      read_valid_in = 1'b0;
      stop_in       = 1'b0;
      resume_in     = 1'b0;
      write_en      = 1'b0;
      unique case (s1_req_ff.kind)
         KIND_READ: begin
            if (head_ff != tail_ff) begin
               tail_in       = tail_next;
               read_valid_in = 1'b1;
               resume_in     = (tail_after == head_ff) && s1_req_ff.peer_stopped;
            end
         end
         default: begin
            stop_in = (stop_wrap[PTR_W-1:0] == tail_ff) && !s1_req_ff.peer_stopped;
            last_error_in = '0;
            if (head_next == tail_ff) begin
               last_error_in[ERR_OVERFLOW_BIT] = 1'b1;
            end else begin
               last_error_in[ERR_FRAME_BIT]   = s1_req_ff.frame_error;
               last_error_in[ERR_OVERRUN_BIT] = s1_req_ff.overrun_error;
               head_in  = head_next;
               write_en = 1'b1;
            end
         end
      endcase
      fill      = (head_in >= tail_in) ? head_in - tail_in
                                       : PTR_W'(DEPTH_WIDE + {1'b0, head_in} - {1'b0, tail_in});
      fill_wide = FILL_W'(fill);
   end

   always_ff @(posedge clock) begin
      if (advance && write_en) begin
         ring_mem[head_next] <= s1_req_ff.rx_byte;
      end
      if (advance) begin
         rsp_read_byte_ff <= read_valid_in ? ring_mem[tail_next] : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff <= '{kind: req_kind, rx_byte: req_rx_byte,
                        frame_error: req_frame_error_in,
                        overrun_error: req_overrun_error_in,
                        peer_stopped: req_peer_stopped};
      end
      if (advance) begin
         rsp_read_valid_ff <= read_valid_in;
         rsp_error_ff      <= last_error_in;
         rsp_fill_count_ff <= fill_wide[7:0];
         rsp_stop_ff       <= stop_in;
         rsp_resume_ff     <= resume_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         head_ff          <= '0;
         tail_ff          <= '0;
         last_error_ff    <= '0;
         stop_distance_ff <= STOP_DISTANCE_RESET;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff  <= 1'b1;
            head_ff       <= head_in;
            tail_ff       <= tail_in;
            last_error_ff <= last_error_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            stop_distance_ff <= csr_write_data;
         end
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_read_valid           = rsp_read_valid_ff;
   assign rsp_read_byte            = rsp_read_byte_ff;
   assign rsp_last_frame_error     = rsp_error_ff[ERR_FRAME_BIT];
   assign rsp_last_overrun_error   = rsp_error_ff[ERR_OVERRUN_BIT];
   assign rsp_last_buffer_overflow = rsp_error_ff[ERR_OVERFLOW_BIT];
   assign rsp_fill_count           = rsp_fill_count_ff;
   assign rsp_stop_request         = rsp_stop_ff;
   assign rsp_resume_request       = rsp_resume_ff;

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (head_ff <= LAST_SLOT) && (tail_ff <= LAST_SLOT))
      else $error("ring pointer beyond the last slot");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && s1_valid_ff) |-> advance)
      else $error("request register overwritten before it moved on");

   a_resume_on_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_resume_ff) |-> (rsp_read_valid_ff && !rsp_stop_ff))
      else $error("resume request without a successful pop");

   a_overflow_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_error_ff[ERR_OVERFLOW_BIT])
         |-> (!rsp_error_ff[ERR_FRAME_BIT] && !rsp_error_ff[ERR_OVERRUN_BIT]))
      else $error("overflow reported together with line errors");

endmodule
